// File: rtl/cfa_pkg.sv
// Shared types and constants for the contiguous fit allocator.
// No dependencies; imported by cfa_fit and contiguous_fit_allocator.
`timescale 1ns / 1ps
`default_nettype none

package cfa_pkg;

    // Operation codes
    localparam logic [1:0] FUNC_ALLOC   = 2'd0;
    localparam logic [1:0] FUNC_RELEASE = 2'd1;
    localparam logic [1:0] FUNC_COMPACT = 2'd2;

    // Fit policies (the unused code behaves as best fit)
    localparam logic [1:0] FIT_FIRST = 2'd0;
    localparam logic [1:0] FIT_BEST  = 2'd1;
    localparam logic [1:0] FIT_WORST = 2'd2;

    // Map entry: bit 8 set means free, else low byte is the owner
    localparam logic [8:0] FREE_MARK = 9'h100;

    localparam logic STATUS_DONE = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    typedef struct packed {
        logic [1:0] func;
        logic [1:0] fit_policy;
        logic [7:0] owner_id;
        logic [8:0] request_size;
    } cmd_t;

    typedef struct packed {
        logic       status;
        logic [8:0] region_start;
    } rsp_t;

    // Per-cycle control from the scan sequencer to the run tracker
    typedef struct packed {
        logic clr;    // new item: forget runs and the current pick
        logic vld;    // one map entry arrives this cycle
        logic free;   // that entry is free
        logic flush;  // end of scan: close an open run
    } fit_ctl_t;

endpackage

`default_nettype wire

// File: rtl/contiguous_fit_allocator.sv
// Top level of the contiguous fit allocator: owner map memory, scan/fill
// sequencer and configuration register. Depends on cfa_pkg and cfa_fit.
`timescale 1ns / 1ps
`default_nettype none

// Contiguous fit allocator. Keeps one owner entry per memory unit in a
// single-port-write / single-port-read synchronous RAM with a registered
// read. A command is taken when start is high and busy is low; busy
// stays high until an allocate, release or compact has put out its result.
// The result is shown on result for exactly one cycle with done high --
// there is no back-pressure, so the receiver must take it in that cycle.
// Work follows the RAM stream, one unit per cycle, with T = total_units:
//   allocate : scan all T units, flush and pick, then on a fit request_size fill writes
//   release  : scan all T units (free entries are written back behind the read)
//   compact  : scan all T units to pack owned units down, then one write per
//              freed unit up to T
//   unused function code: result the cycle after acceptance.
// After reset the RAM is swept to all free, one entry a cycle, and busy is
// high for the whole sweep before the first command; configuration writes
// are accepted throughout. total_units must only be written while idle;
// values above MAX_UNITS saturate to MAX_UNITS.

module contiguous_fit_allocator
    import cfa_pkg::*;
#(
    parameter int MAX_UNITS = 256
) (
    input  wire        clk,
    input  wire        rst_n,
    input  wire        start,
    output logic       busy,
    input  cmd_t       cmd,
    input  wire        cfg_we,
    input  wire  [8:0] cfg_wdata,
    output logic       done,
    output rsp_t       result
);

    // address width, and counter width that holds total_units itself
    localparam int AW      = $clog2(MAX_UNITS);
    localparam int CW0     = $clog2(MAX_UNITS + 1);
    localparam int LW      = (CW0 > 9) ? CW0 : 9;
    localparam int TOT_RST = (MAX_UNITS < 256) ? MAX_UNITS : 256;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH,
        ST_DECIDE,
        ST_FILL
    } state_t;

    state_t        state_reg, state_next;
    logic [AW-1:0] clr_reg, clr_next;      // reset sweep address
    cmd_t          req_reg, req_next;      // item being worked on
    logic [LW-1:0] ri_reg, ri_next;        // next unit to read
    logic          dv_reg, dv_next;        // read data valid this cycle
    logic [LW-1:0] di_reg, di_next;        // unit of the read data
    logic [LW-1:0] wp_reg, wp_next;        // compact write pointer
    logic [LW-1:0] fp_reg, fp_next;        // fill pointer
    logic [LW-1:0] fe_reg, fe_next;        // fill end (exclusive)
    logic [LW-1:0] tot_reg;
    logic          done_reg, done_next;
    rsp_t          rsp_reg, rsp_next;

    // owner map
    logic [8:0]    mem [MAX_UNITS];
    logic [8:0]    mem_q_reg;
    logic          mem_re, mem_we;
    logic [AW-1:0] mem_ra, mem_wa;
    logic [8:0]    mem_wd;

    fit_ctl_t      fit_ctl;
    logic          fit_found;
    logic [LW-1:0] fit_start;
    logic [LW-1:0] cfg_x;

    cfa_fit #(
        .LW (LW)
    ) u_fit (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (fit_ctl),
        .idx        (di_reg),
        .policy     (req_reg.fit_policy),
        .size       (req_reg.request_size),
        .found      (fit_found),
        .best_start (fit_start)
    );

    // configuration register with saturation at the store depth
    assign cfg_x = LW'(cfg_wdata);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tot_reg <= LW'(TOT_RST);
        end
        else if (cfg_we)
        begin
            tot_reg <= (cfg_x > LW'(MAX_UNITS)) ? LW'(MAX_UNITS) : cfg_x;
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        req_next   = req_reg;
        ri_next    = ri_reg;
        dv_next    = 1'b0;
        di_next    = di_reg;
        wp_next    = wp_reg;
        fp_next    = fp_reg;
        fe_next    = fe_reg;
        done_next  = 1'b0;
        rsp_next   = rsp_reg;
        mem_re     = 1'b0;
        mem_ra     = ri_reg[AW-1:0];
        mem_we     = 1'b0;
        mem_wa     = fp_reg[AW-1:0];
        mem_wd     = FREE_MARK;
        fit_ctl    = '0;

        case (state_reg)
            ST_CLEAR:
            begin
                mem_we   = 1'b1;
                mem_wa   = clr_reg;
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(MAX_UNITS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (start)
                begin
                    req_next    = cmd;
                    ri_next     = '0;
                    wp_next     = '0;
                    fit_ctl.clr = 1'b1;
                    if (cmd.func == FUNC_ALLOC || cmd.func == FUNC_RELEASE ||
                        cmd.func == FUNC_COMPACT)
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        // unused code: nothing changes
                        done_next = 1'b1;
                        rsp_next  = '0;
                    end
                end
            end

            ST_SCAN:
            begin
                // stream reads one unit a cycle
                if (ri_reg < tot_reg)
                begin
                    mem_re  = 1'b1;
                    ri_next = ri_reg + LW'(1);
                    dv_next = 1'b1;
                    di_next = ri_reg;
                end
                // handle the entry read last cycle; writes stay behind reads
                if (dv_reg)
                begin
                    case (req_reg.func)
                        FUNC_ALLOC:
                        begin
                            fit_ctl.vld  = 1'b1;
                            fit_ctl.free = mem_q_reg[8];
                        end
                        FUNC_RELEASE:
                        begin
                            if (mem_q_reg == {1'b0, req_reg.owner_id})
                            begin
                                mem_we = 1'b1;
                                mem_wa = di_reg[AW-1:0];
                                mem_wd = FREE_MARK;
                            end
                        end
                        default:
                        begin
                            // compact: pack owned entries down in order
                            if (!mem_q_reg[8])
                            begin
                                mem_we  = 1'b1;
                                mem_wa  = wp_reg[AW-1:0];
                                mem_wd  = mem_q_reg;
                                wp_next = wp_reg + LW'(1);
                            end
                        end
                    endcase
                end
                if (ri_reg == tot_reg && !dv_reg)
                begin
                    case (req_reg.func)
                        FUNC_ALLOC:
                        begin
                            state_next = ST_FLUSH;
                        end
                        FUNC_RELEASE:
                        begin
                            state_next = ST_IDLE;
                            done_next  = 1'b1;
                            rsp_next   = '0;
                        end
                        default:
                        begin
                            // free the tail above the packed units
                            fp_next               = wp_reg;
                            fe_next               = tot_reg;
                            rsp_next.status       = STATUS_DONE;
                            rsp_next.region_start = wp_reg[8:0];
                            state_next            = ST_FILL;
                        end
                    endcase
                end
            end

            ST_FLUSH:
            begin
                fit_ctl.flush = 1'b1;
                state_next    = ST_DECIDE;
            end

            ST_DECIDE:
            begin
                if (fit_found)
                begin
                    fp_next               = fit_start;
                    fe_next               = fit_start + LW'(req_reg.request_size);
                    rsp_next.status       = STATUS_DONE;
                    rsp_next.region_start = fit_start[8:0];
                    state_next            = ST_FILL;
                end
                else
                begin
                    rsp_next.status       = STATUS_FAIL;
                    rsp_next.region_start = '0;
                    done_next             = 1'b1;
                    state_next            = ST_IDLE;
                end
            end

            ST_FILL:
            begin
                if (fp_reg < fe_reg)
                begin
                    mem_we  = 1'b1;
                    mem_wa  = fp_reg[AW-1:0];
                    mem_wd  = (req_reg.func == FUNC_ALLOC) ? {1'b0, req_reg.owner_id}
                                                           : FREE_MARK;
                    fp_next = fp_reg + LW'(1);
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            ri_reg    <= '0;
            dv_reg    <= 1'b0;
            di_reg    <= '0;
            wp_reg    <= '0;
            fp_reg    <= '0;
            fe_reg    <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            ri_reg    <= ri_next;
            dv_reg    <= dv_next;
            di_reg    <= di_next;
            wp_reg    <= wp_next;
            fp_reg    <= fp_next;
            fe_reg    <= fe_next;
            done_reg  <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        rsp_reg <= rsp_next;
    end

    // owner map RAM: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re)
        begin
            mem_q_reg <= mem[mem_ra];
        end
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = rsp_reg;

    // no RAM write while idle
    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !mem_we)
        else $error("map written while idle");

    // compaction never writes ahead of the entry being examined
    a_compact_behind: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && dv_reg && req_reg.func == FUNC_COMPACT) |->
        (wp_reg <= di_reg))
        else $error("compact write pointer overtook read");

    // fills stay inside the units in use
    a_fill_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FILL) |-> (fe_reg <= tot_reg && fp_reg <= fe_reg))
        else $error("fill outside units in use");

    // a failed allocate reports region 0
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && rsp_reg.status == STATUS_FAIL) |-> (rsp_reg.region_start == '0))
        else $error("failed allocate with nonzero region");

    // an accepted real command keeps the block busy
    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (cmd.func == FUNC_ALLOC || cmd.func == FUNC_RELEASE ||
         cmd.func == FUNC_COMPACT)) |=> (busy && !done))
        else $error("command accepted without going busy");

endmodule

`default_nettype wire

// File: rtl/cfa_fit.sv
// Free-run tracker: follows runs of free units in scan order and keeps
// the pick for first, best or worst fit. Depends on cfa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cfa_fit
    import cfa_pkg::*;
#(
    parameter int LW = 9
) (
    input  wire             clk,
    input  wire             rst_n,
    input  fit_ctl_t        ctl,
    input  wire  [LW-1:0]   idx,
    input  wire  [1:0]      policy,
    input  wire  [8:0]      size,
    output logic            found,
    output logic [LW-1:0]   best_start
);

    logic          in_run_reg, in_run_next;
    logic [LW-1:0] cur_start_reg, cur_start_next;
    logic [LW-1:0] cur_len_reg, cur_len_next;
    logic          fnd_reg, fnd_next;
    logic [LW-1:0] best_s_reg, best_s_next;
    logic [LW-1:0] best_len_reg, best_len_next;

    logic [LW-1:0] size_x;
    logic          close_run;
    logic          fits;
    logic          take;

    assign size_x    = LW'(size);
    assign close_run = in_run_reg && ((ctl.vld && !ctl.free) || ctl.flush);
    assign fits      = cur_len_reg >= size_x;

    always_comb
    begin
        case (policy)
            FIT_FIRST: take = fits && !fnd_reg;
            FIT_WORST: take = cur_len_reg > best_len_reg;
            default:   take = fits && (!fnd_reg || cur_len_reg < best_len_reg);
        endcase
    end

    always_comb
    begin
        in_run_next    = in_run_reg;
        cur_start_next = cur_start_reg;
        cur_len_next   = cur_len_reg;
        fnd_next       = fnd_reg;
        best_s_next    = best_s_reg;
        best_len_next  = best_len_reg;
        if (ctl.clr)
        begin
            in_run_next   = 1'b0;
            cur_len_next  = '0;
            fnd_next      = 1'b0;
            best_s_next   = '0;
            best_len_next = '0;
        end
        else
        begin
            if (close_run && take)
            begin
                fnd_next      = 1'b1;
                best_s_next   = cur_start_reg;
                best_len_next = cur_len_reg;
            end
            if (ctl.vld)
            begin
                if (ctl.free)
                begin
                    if (in_run_reg)
                    begin
                        cur_len_next = cur_len_reg + LW'(1);
                    end
                    else
                    begin
                        in_run_next    = 1'b1;
                        cur_start_next = idx;
                        cur_len_next   = LW'(1);
                    end
                end
                else
                begin
                    in_run_next = 1'b0;
                end
            end
            if (ctl.flush)
            begin
                in_run_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_run_reg    <= 1'b0;
            cur_start_reg <= '0;
            cur_len_reg   <= '0;
            fnd_reg       <= 1'b0;
            best_s_reg    <= '0;
            best_len_reg  <= '0;
        end
        else
        begin
            in_run_reg    <= in_run_next;
            cur_start_reg <= cur_start_next;
            cur_len_reg   <= cur_len_next;
            fnd_reg       <= fnd_next;
            best_s_reg    <= best_s_next;
            best_len_reg  <= best_len_next;
        end
    end

    // worst fit only learns at the end whether the largest run is enough
    assign found      = fnd_reg && ((policy != FIT_WORST) || (best_len_reg >= size_x));
    assign best_start = best_s_reg;

    // a kept pick is never an empty run
    a_pick_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        fnd_reg |-> (best_len_reg != '0))
        else $error("fit pick with zero length");

    // an open run always has at least one unit
    a_run_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        in_run_reg |-> (cur_len_reg != '0))
        else $error("open run with zero length");

    // a reported fit is large enough for the request
    a_found_fits: assert property (@(posedge clk) disable iff (!rst_n)
        found |-> (best_len_reg >= size_x))
        else $error("reported fit smaller than request");

endmodule

`default_nettype wire
